/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros included by the RTL
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sfcc_pkg.sv */
// ----------------------------------------------------------------------------
// sfcc_pkg
// Types, constants and helper functions of the sensor frame checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfcc_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_BAD = 2'd1,
        STATUS_HUM_BAD  = 2'd2
    } status_t;

    // Byte positions inside the six-byte frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // CRC-8, polynomial 0x31, init 0xFF, no reflection, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Conversion constants
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] HUM_MAX     = 15'd10000;

    // One byte through the CRC, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // floor(x / 65535) for quotients below 65536: (x + (x >> 16) + 1) >> 16
    function automatic logic [15:0] div_by_full(input logic [31:0] x);
        logic [32:0] s;
        s = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
        return s[31:16];
    endfunction

endpackage

`default_nettype wire

/* sv/sensor_frame_crc_check_convert.sv */
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_convert
// Checks the two CRC-8 bytes of a six-byte sensor frame and converts the
// raw temperature and humidity words to hundredths.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------------------
//   input   | in_valid/in_ready  | data_byte[7:0], frame_start
//   output  | out_valid/out_ready| status[1:0], temperature_x100[14:0] s,
//           |                    | rel_humidity[13:0]
//
// One byte is taken per cycle while in_ready is high. The result register
// loads at the edge that takes the sixth byte, so out_valid is high from the
// next cycle on. in_ready drops only while a result waits in the output
// register with out_ready low; the next byte then waits.
// Reset returns the byte position to the first byte and empties the result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_crc_check_convert (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 frame_start,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output sfcc_pkg::status_t         status,
    output logic signed [14:0]        temperature_x100,
    output logic [13:0]               rel_humidity
);
    import sfcc_pkg::*;

    `include "assert_macros.svh"

    // Frame state
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [7:0]  hum_lo_reg, hum_lo_next;
    logic        temp_bad_reg, temp_bad_next;

    // Output stage
    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg, out_status_next;
    logic [14:0] out_t_reg, out_t_next;
    logic [13:0] out_h_reg, out_h_next;

    logic        in_accept;
    logic        last_accept;
    logic [2:0]  pos;
    logic [30:0] t_prod;
    logic [29:0] h_prod;
    logic [15:0] t_quot;
    logic [15:0] h_quot;

    // Flow control
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Frame state update
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_hi_next    = hum_hi_reg;
        hum_lo_next    = hum_lo_reg;
        temp_bad_next  = temp_bad_reg;
        last_accept    = 1'b0;

        pos = frame_start ? POS_T_HI : pos_reg;
        if (!(pos inside {[POS_T_HI:POS_H_CRC]}))
            pos = POS_T_HI;

        if (in_accept)
        begin
            case (pos)
                POS_T_HI:
                begin
                    crc_next       = crc8_update(CRC_INIT, data_byte);
                    temp_word_next = {data_byte, 8'd0};
                end
                POS_T_LO:
                begin
                    crc_next       = crc8_update(crc_reg, data_byte);
                    temp_word_next = {temp_word_reg[15:8], data_byte};
                end
                POS_T_CRC:
                begin
                    temp_bad_next = (crc_reg != data_byte);
                    crc_next      = CRC_INIT;
                end
                POS_H_HI:
                begin
                    crc_next    = crc8_update(crc_reg, data_byte);
                    hum_hi_next = data_byte;
                end
                POS_H_LO:
                begin
                    crc_next    = crc8_update(crc_reg, data_byte);
                    hum_lo_next = data_byte;
                end
                default:
                begin
                    last_accept = 1'b1;
                    crc_next    = CRC_INIT;
                end
            endcase
            pos_next = (pos == POS_H_CRC) ? POS_T_HI : pos + 3'd1;
        end
    end

    // Scale multiplies and divide by 65535
    assign t_prod = {15'd0, temp_word_reg} * {16'd0, TEMP_SCALE};
    assign h_prod = {14'd0, hum_hi_reg, hum_lo_reg} * {16'd0, HUM_SCALE};
    assign t_quot = div_by_full({1'b0, t_prod});
    assign h_quot = div_by_full({2'b00, h_prod});

    // Status, offset and zero on error, loaded on the last byte
    always_comb
    begin
        out_status_next = out_status_reg;
        out_t_next      = out_t_reg;
        out_h_next      = out_h_reg;
        if (last_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        if (last_accept)
        begin
            if (temp_bad_reg)
            begin
                out_status_next = STATUS_TEMP_BAD;
                out_t_next      = 15'd0;
                out_h_next      = 14'd0;
            end
            else if (crc_reg != data_byte)
            begin
                out_status_next = STATUS_HUM_BAD;
                out_t_next      = 15'd0;
                out_h_next      = 14'd0;
            end
            else
            begin
                out_status_next = STATUS_OK;
                out_t_next      = t_quot[14:0] - TEMP_OFFSET;
                out_h_next      = h_quot[13:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_T_HI;
            crc_reg        <= CRC_INIT;
            temp_bad_reg   <= 1'b0;
            temp_word_reg  <= 16'd0;
            hum_hi_reg     <= 8'd0;
            hum_lo_reg     <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            temp_bad_reg   <= temp_bad_next;
            temp_word_reg  <= temp_word_next;
            hum_hi_reg     <= hum_hi_next;
            hum_lo_reg     <= hum_lo_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg  <= out_status_next;
        out_t_reg       <= out_t_next;
        out_h_reg       <= out_h_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign temperature_x100 = $signed(out_t_reg);
    assign rel_humidity     = out_h_reg;

    // Checks
    `ASSERT_IMPLIES(a_pos_range, 1'b1, pos_reg <= POS_H_CRC, "byte position out of range")
    `ASSERT_NEXT(a_last_loads, last_accept, out_valid_reg, "last byte did not load result")
    `ASSERT_IMPLIES(a_zero_on_err, out_valid && (status != STATUS_OK),
        (temperature_x100 == 15'sd0) && (rel_humidity == 14'd0), "nonzero values on CRC error")
    `ASSERT_IMPLIES(a_hum_range, out_valid && (status == STATUS_OK),
        {1'b0, rel_humidity} <= HUM_MAX, "humidity above full scale")

endmodule

`default_nettype wire

/* sim/sensor_frame_crc_check_convert_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_convert_test
// Drives six-byte sensor frames into the checker and compares every reading
// against an in-bench predictor of the CRC-8 checks and the unit conversion.
// The sequence is: directed frames, random well-formed frames, a drain pause,
// truncated and noisy byte streams, and a final stretch at full rate.
// ----------------------------------------------------------------------------

module sensor_frame_crc_check_convert_test;
    import sfcc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;
    localparam int FRAME_BYTES  = 6;

    // Conversion constants
    localparam int unsigned TEMP_SPAN = 17500;
    localparam int unsigned HUM_SPAN  = 10000;
    localparam int unsigned RAW_FULL  = 65535;
    localparam int          TEMP_BASE = 4500;

    typedef struct {
        status_t            st;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } reading_t;

    // DUT signals
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic [7:0]         data_byte   = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_ready   = 1'b0;
    logic               in_ready;
    logic               out_valid;
    status_t            status;
    logic signed [14:0] temperature_x100;
    logic [13:0]        rel_humidity;

    // Predictor state, reset values as in the block
    logic [2:0]  frame_pos       = POS_T_HI;
    logic [7:0]  word_crc        = CRC_INIT;
    logic [15:0] raw_temp        = 16'h0000;
    logic [7:0]  raw_hum_hi      = 8'h00;
    logic [7:0]  raw_hum_lo      = 8'h00;
    logic        temp_crc_failed = 1'b0;

    reading_t    readings_due[$];
    int unsigned mismatches     = 0;
    int unsigned readings_seen  = 0;
    int unsigned bytes_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned status_hits[3] = '{0, 0, 0};
    bit          sender_idles    = 1'b0;
    bit          receiver_stalls = 1'b1;

    sensor_frame_crc_check_convert DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .frame_start      (frame_start),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .temperature_x100 (temperature_x100),
        .rel_humidity     (rel_humidity)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout: %0d readings still due", readings_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // CRC-8 over one byte, shifting in one data bit at a time
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic feedback;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = crc[7] ^ b[i];
            crc      = {crc[6:0], 1'b0};
            if (feedback)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    function automatic logic [7:0] word_crc8(input logic [15:0] w);
        return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Raw sensor word, extremes weighted up
    function automatic logic [15:0] random_raw();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Mask xored into a CRC byte; zero most of the time
    function automatic logic [7:0] random_flip();
        if ($urandom_range(0, 5) == 0)
            return 8'($urandom_range(1, 255));
        return 8'h00;
    endfunction

    // Advance the predictor by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic fs);
        logic [2:0]  pos;
        reading_t    r;
        int unsigned scaled;
        int          temp_c;
        pos = fs ? POS_T_HI : frame_pos;
        if (pos > POS_H_CRC)
            pos = POS_T_HI;
        case (pos)
            POS_T_HI:
            begin
                word_crc = crc8_step(CRC_INIT, b);
                raw_temp = {b, 8'h00};
            end
            POS_T_LO:
            begin
                word_crc      = crc8_step(word_crc, b);
                raw_temp[7:0] = b;
            end
            POS_T_CRC:
            begin
                temp_crc_failed = (word_crc != b);
                word_crc        = CRC_INIT;
            end
            POS_H_HI:
            begin
                word_crc   = crc8_step(word_crc, b);
                raw_hum_hi = b;
            end
            POS_H_LO:
            begin
                word_crc   = crc8_step(word_crc, b);
                raw_hum_lo = b;
            end
            default:
            begin
                r.st   = STATUS_OK;
                r.temp = '0;
                r.hum  = '0;
                if (temp_crc_failed)
                    r.st = STATUS_TEMP_BAD;
                else if (word_crc != b)
                    r.st = STATUS_HUM_BAD;
                else
                begin
                    scaled = (TEMP_SPAN * {16'h0000, raw_temp}) / RAW_FULL;
                    temp_c = int'(scaled) - TEMP_BASE;
                    r.temp = temp_c[14:0];
                    scaled = (HUM_SPAN * {16'h0000, raw_hum_hi, raw_hum_lo}) / RAW_FULL;
                    r.hum  = scaled[13:0];
                end
                readings_due.push_back(r);
                word_crc = CRC_INIT;
            end
        endcase
        frame_pos = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;
    endtask

    // Offer one byte and wait for the handshake; called at a rising edge
    task automatic send_byte(input logic [7:0] b, input logic fs);
        logic ready_seen;
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= fs;
        do
        begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end
        while (!ready_seen);
        predict_byte(b, fs);
        bytes_sent++;
    endtask

    // First len bytes of a frame; flips corrupt the CRC bytes
    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic [7:0] t_flip, input logic [7:0] h_flip,
                              input logic mark, input int len);
        logic [7:0] frame_bytes[FRAME_BYTES];
        frame_bytes[0] = t_raw[15:8];
        frame_bytes[1] = t_raw[7:0];
        frame_bytes[2] = word_crc8(t_raw) ^ t_flip;
        frame_bytes[3] = h_raw[15:8];
        frame_bytes[4] = h_raw[7:0];
        frame_bytes[5] = word_crc8(h_raw) ^ h_flip;
        for (int k = 0; k < len; k++)
            send_byte(frame_bytes[k], (k == 0) ? mark : 1'b0);
    endtask

    task automatic send_random_frame(input bit force_mark);
        logic mark;
        mark = force_mark || (frame_pos != POS_T_HI) || ($urandom_range(0, 1) == 1);
        send_frame(random_raw(), random_raw(), random_flip(), random_flip(), mark,
                   FRAME_BYTES);
    endtask

    task automatic report_mismatch(input string what, input reading_t want,
                                   input reading_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected %s/%0d/%0d, got %s/%0d/%0d", $realtime, what,
                     want.st.name(), want.temp, want.hum, got.st.name(), got.temp, got.hum);
    endtask

    // ---------------------------------------------------------------- tests

    // Scale extremes, every status, resync on a mid-frame start
    task automatic test_directed();
        sender_idles = 1'b0;
        // no frame start anywhere: position counted from reset
        send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, FRAME_BYTES);
        // frame start on the first byte changes nothing
        send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1, FRAME_BYTES);
        // two bytes dropped by a restart, then both CRCs bad
        send_frame(16'hBEEF, 16'h0000, 8'h00, 8'h00, 1'b1, 2);
        send_frame(16'h6666, 16'h8000, 8'h01, 8'h80, 1'b1, FRAME_BYTES);
        // humidity CRC bad only
        send_frame(16'hBEEF, 16'h1234, 8'h00, 8'hFF, 1'b1, FRAME_BYTES);
    endtask

    task automatic test_clean_frames(input int count);
        for (int i = 0; i < count; i++)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            send_random_frame(1'b0);
        end
    endtask

    // Sender holds off until the pipeline is empty
    task automatic test_sender_pause();
        test_clean_frames(4);
        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        test_clean_frames(4);
    endtask

    // Noise bytes, truncated frames, unmarked frames and marked whole frames
    task automatic test_broken_frames(input int count);
        int unsigned stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                1:       send_frame(random_raw(), random_raw(), random_flip(), random_flip(),
                                    1'b1, $urandom_range(1, FRAME_BYTES - 1));
                2:       send_frame(random_raw(), random_raw(), random_flip(), random_flip(),
                                    1'b0, FRAME_BYTES);
                default: send_random_frame(1'b1);
            endcase
        end
    endtask

    // Back to back frames, no idling on either side
    task automatic test_streaming(input int count);
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        for (int i = 0; i < count; i++)
            send_random_frame(1'b0);
    endtask

    // ------------------------------------------------------------ processes

    // Receiver: ready stretches broken by stall bursts while receiver_stalls is set
    initial
    begin
        forever
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat (100) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
            if (receiver_stalls)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
    end

    // Reading checker: sample mid-cycle, act on the following edge
    initial
    begin
        reading_t got;
        reading_t want;
        logic     fire;
        forever
        begin
            @(negedge clk);
            fire     = rst_n && out_valid && out_ready;
            got.st   = status;
            got.temp = temperature_x100;
            got.hum  = rel_humidity;
            @(posedge clk);
            if (fire)
            begin
                readings_seen++;
                if (int'(got.st) < 3)
                    status_hits[int'(got.st)]++;
                if (readings_due.size() == 0)
                begin
                    want = got;
                    report_mismatch("reading with none due", want, got);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.st !== want.st || got.temp !== want.temp || got.hum !== want.hum)
                        report_mismatch("reading mismatch", want, got);
                end
            end
        end
    end

    // Sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_clean_frames(170);
        test_sender_pause();
        test_broken_frames(300);
        test_streaming(40);

        in_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes; checked %0d readings: %0d ok, %0d temp CRC bad, %0d hum CRC bad",
                 bytes_sent, readings_seen, status_hits[0], status_hits[1], status_hits[2]);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/sfcc_pkg.sv
sv/sensor_frame_crc_check_convert.sv
sim/sensor_frame_crc_check_convert_test.sv
